### rtl/edfadm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF admission scheduler package
// Shared types, codes and sizes of the job table and its sequencer.
// ----------------------------------------------------------------------------
package edfadm_pkg;

   // Table geometry. Item index MAX_JOBS stands for the job under test.
   localparam int MAX_JOBS = 16;
   localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int ITEM_W   = $clog2(MAX_JOBS + 1);

   // Datapath widths.
   localparam int ID_W   = 32;
   localparam int TIME_W = 48;
   localparam int COST_W = 32;
   localparam int CAP_W  = 8;
   localparam int PROD_W = CAP_W + TIME_W;
   localparam int SUM_W  = (COST_W - 1) + ITEM_W;

   typedef enum logic [1:0] {
      FUNC_ADMIT    = 2'd0,
      FUNC_ENQUEUE  = 2'd1,
      FUNC_NEXT     = 2'd2,
      FUNC_COMPLETE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_FREE     = 2'd0,
      KIND_RESERVED = 2'd1,
      KIND_PENDING  = 2'd2,
      KIND_INFLIGHT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK    = 3'd0,
      STAT_LATE  = 3'd1,
      STAT_OVER  = 3'd2,
      STAT_FULL  = 3'd3,
      STAT_EMPTY = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_OUTER,
      ST_PROD,
      ST_INNER,
      ST_CHECK,
      ST_PASS,
      ST_NEXT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]               func;
      logic [ID_W-1:0]          job_id;
      logic [TIME_W-1:0]        deadline_us;
      logic signed [COST_W-1:0] cost_us;
      logic [TIME_W-1:0]        now_us;
   } req_type;

   typedef struct packed {
      logic            accepted;
      logic [2:0]      status;
      logic [ID_W-1:0] job_id_out;
   } rsp_type;

   // One table entry as seen at the read port.
   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] dl;
      logic [COST_W-1:0] cost;
   } entry_type;

   // Write command from the sequencer to the table.
   typedef struct packed {
      logic              we;
      logic              kind_we;
      logic [SLOT_W-1:0] slot;
      kind_type          kind;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] dl;
      logic [COST_W-1:0] cost;
   } wr_type;

endpackage

### rtl/edfadm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF job table
// Entry kinds in reset flip-flops, entry payload in plain registers, one
// read port and one write port.
// ----------------------------------------------------------------------------
module edfadm_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [edfadm_pkg::SLOT_W-1:0]   rd_slot,
   output edfadm_pkg::entry_type           rd_entry,
   input  edfadm_pkg::wr_type              wr
);

   edfadm_pkg::kind_type                     kind_ff [edfadm_pkg::MAX_JOBS];
   logic [edfadm_pkg::ID_W-1:0]              id_ff   [edfadm_pkg::MAX_JOBS];
   logic [edfadm_pkg::TIME_W-1:0]            dl_ff   [edfadm_pkg::MAX_JOBS];
   logic [edfadm_pkg::COST_W-1:0]            cost_ff [edfadm_pkg::MAX_JOBS];

   // Kinds are control state: reset frees every entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < edfadm_pkg::MAX_JOBS; i++) begin
            kind_ff[i] <= edfadm_pkg::KIND_FREE;
         end
      end else if (wr.we || wr.kind_we) begin
         kind_ff[wr.slot] <= wr.kind;
      end
   end

   // Payload is only read for entries that were written first.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         id_ff[wr.slot]   <= wr.id;
         dl_ff[wr.slot]   <= wr.dl;
         cost_ff[wr.slot] <= wr.cost;
      end
   end

   // Single read port.
   always_comb begin
      rd_entry.kind = kind_ff[rd_slot];
      rd_entry.id   = id_ff[rd_slot];
      rd_entry.dl   = dl_ff[rd_slot];
      rd_entry.cost = cost_ff[rd_slot];
   end

endmodule

### rtl/edfadm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF sequencer
// Walks the job table one entry per cycle for lookups and runs the demand
// bound test with one shared compare, add and multiply datapath.
// ----------------------------------------------------------------------------
module edfadm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  edfadm_pkg::req_type             req,
   input  logic [edfadm_pkg::CAP_W-1:0]    cap,
   input  logic                            out_free,
   output logic                            busy,
   output logic                            res_load,
   output edfadm_pkg::rsp_type             res,
   output logic [edfadm_pkg::SLOT_W-1:0]   rd_slot,
   input  edfadm_pkg::entry_type           rd_entry,
   output edfadm_pkg::wr_type              wr
);

   localparam logic [edfadm_pkg::ITEM_W-1:0] NEW_ITEM  = edfadm_pkg::ITEM_W'(edfadm_pkg::MAX_JOBS);
   localparam logic [edfadm_pkg::ITEM_W-1:0] LAST_SLOT =
      edfadm_pkg::ITEM_W'(edfadm_pkg::MAX_JOBS - 1);

   edfadm_pkg::state_type               state_ff, state_in;
   edfadm_pkg::req_type                 req_ff, req_in;
   logic [edfadm_pkg::ITEM_W-1:0]       idx_ff, idx_in;
   logic [edfadm_pkg::ITEM_W-1:0]       k_ff, k_in;
   logic                                res_hit_ff, res_hit_in;
   logic [edfadm_pkg::SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic                                free_hit_ff, free_hit_in;
   logic [edfadm_pkg::SLOT_W-1:0]       free_slot_ff, free_slot_in;
   logic                                inf_hit_ff, inf_hit_in;
   logic [edfadm_pkg::SLOT_W-1:0]       inf_slot_ff, inf_slot_in;
   logic                                late_ff, late_in;
   logic                                pend_hit_ff, pend_hit_in;
   logic [edfadm_pkg::SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [edfadm_pkg::TIME_W-1:0]       pend_dl_ff, pend_dl_in;
   logic [edfadm_pkg::ID_W-1:0]         pend_id_ff, pend_id_in;
   logic                                dup_ff, dup_in;
   logic [edfadm_pkg::TIME_W-1:0]       dk_ff, dk_in;
   logic [edfadm_pkg::TIME_W-1:0]       diff_ff, diff_in;
   logic [edfadm_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [edfadm_pkg::SUM_W-1:0]        sum_ff, sum_in;
   edfadm_pkg::rsp_type                 res_ff, res_in;

   logic [edfadm_pkg::ITEM_W-1:0]       rd_item;
   logic                                is_new;
   logic                                ent_counted;
   logic                                item_counted;
   logic [edfadm_pkg::TIME_W-1:0]       item_dl;
   logic [edfadm_pkg::COST_W-2:0]       item_mag;
   logic                                req_cost_pos;
   logic [edfadm_pkg::CAP_W-1:0]        cap_eff;
   logic                                id_match;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edfadm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      free_hit_ff  <= free_hit_in;
      free_slot_ff <= free_slot_in;
      inf_hit_ff   <= inf_hit_in;
      inf_slot_ff  <= inf_slot_in;
      late_ff      <= late_in;
      pend_hit_ff  <= pend_hit_in;
      pend_slot_ff <= pend_slot_in;
      pend_dl_ff   <= pend_dl_in;
      pend_id_ff   <= pend_id_in;
      dup_ff       <= dup_in;
      dk_ff        <= dk_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
   end

   // Read address and the view of the current item. The last item index
   // is the job under test, which lives in the request register.
   always_comb begin
      rd_item      = (state_ff == edfadm_pkg::ST_OUTER) ? k_ff : idx_ff;
      rd_slot      = rd_item[edfadm_pkg::SLOT_W-1:0];
      is_new       = (rd_item == NEW_ITEM);
      ent_counted  = (rd_entry.kind != edfadm_pkg::KIND_FREE) &&
                     !rd_entry.cost[edfadm_pkg::COST_W-1] && (rd_entry.cost != '0);
      item_counted = is_new || ent_counted;
      item_dl      = is_new ? req_ff.deadline_us : rd_entry.dl;
      item_mag     = is_new ? req_ff.cost_us[edfadm_pkg::COST_W-2:0]
                            : rd_entry.cost[edfadm_pkg::COST_W-2:0];
      req_cost_pos = (req_ff.cost_us > 0);
      cap_eff      = (cap == '0) ? edfadm_pkg::CAP_W'(1) : cap;
      id_match     = (rd_entry.id == req_ff.job_id);
   end

   // Next state, datapath updates and table writes.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      free_hit_in  = free_hit_ff;
      free_slot_in = free_slot_ff;
      inf_hit_in   = inf_hit_ff;
      inf_slot_in  = inf_slot_ff;
      late_in      = late_ff;
      pend_hit_in  = pend_hit_ff;
      pend_slot_in = pend_slot_ff;
      pend_dl_in   = pend_dl_ff;
      pend_id_in   = pend_id_ff;
      dup_in       = dup_ff;
      dk_in        = dk_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      res_load     = 1'b0;
      wr           = '0;
      wr.id        = req_ff.job_id;
      wr.dl        = req_ff.deadline_us;
      wr.cost      = req_ff.cost_us;

      unique case (state_ff)
         edfadm_pkg::ST_IDLE: begin
            if (start) begin
               req_in      = req;
               idx_in      = '0;
               res_hit_in  = 1'b0;
               free_hit_in = 1'b0;
               inf_hit_in  = 1'b0;
               late_in     = 1'b0;
               pend_hit_in = 1'b0;
               dup_in      = 1'b0;
               res_in      = '0;
               state_in    = edfadm_pkg::ST_LOOKUP;
            end
         end

         // One entry per cycle: id matches, first free slot, late deadlines
         // and the earliest pending entry.
         edfadm_pkg::ST_LOOKUP: begin
            if (!res_hit_ff && rd_entry.kind == edfadm_pkg::KIND_RESERVED && id_match) begin
               res_hit_in  = 1'b1;
               res_slot_in = rd_slot;
            end
            if (!free_hit_ff && rd_entry.kind == edfadm_pkg::KIND_FREE) begin
               free_hit_in  = 1'b1;
               free_slot_in = rd_slot;
            end
            if (!inf_hit_ff && rd_entry.kind == edfadm_pkg::KIND_INFLIGHT && id_match) begin
               inf_hit_in  = 1'b1;
               inf_slot_in = rd_slot;
            end
            if (ent_counted && rd_entry.dl < req_ff.now_us) begin
               late_in = 1'b1;
            end
            if (rd_entry.kind == edfadm_pkg::KIND_PENDING &&
                (!pend_hit_ff || rd_entry.dl < pend_dl_ff)) begin
               pend_hit_in  = 1'b1;
               pend_slot_in = rd_slot;
               pend_dl_in   = rd_entry.dl;
               pend_id_in   = rd_entry.id;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = edfadm_pkg::ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         edfadm_pkg::ST_DECIDE: begin
            state_in = edfadm_pkg::ST_RESP;
            k_in     = '0;
            unique case (edfadm_pkg::func_type'(req_ff.func))
               edfadm_pkg::FUNC_ADMIT: begin
                  if (!req_cost_pos) begin
                     res_in.accepted = 1'b1;
                  end else if (req_ff.deadline_us <= req_ff.now_us || late_ff) begin
                     res_in.status = edfadm_pkg::STAT_LATE;
                  end else begin
                     state_in = edfadm_pkg::ST_OUTER;
                  end
               end
               edfadm_pkg::FUNC_ENQUEUE: begin
                  if (res_hit_ff) begin
                     wr.we           = 1'b1;
                     wr.slot         = res_slot_ff;
                     wr.kind         = edfadm_pkg::KIND_PENDING;
                     res_in.accepted = 1'b1;
                  end else if (!req_cost_pos) begin
                     if (free_hit_ff) begin
                        wr.we           = 1'b1;
                        wr.slot         = free_slot_ff;
                        wr.kind         = edfadm_pkg::KIND_PENDING;
                        res_in.accepted = 1'b1;
                     end else begin
                        res_in.status = edfadm_pkg::STAT_FULL;
                     end
                  end else if (req_ff.deadline_us <= req_ff.now_us || late_ff) begin
                     res_in.status = edfadm_pkg::STAT_LATE;
                  end else begin
                     state_in = edfadm_pkg::ST_OUTER;
                  end
               end
               edfadm_pkg::FUNC_NEXT: begin
                  if (!pend_hit_ff) begin
                     res_in.status = edfadm_pkg::STAT_EMPTY;
                  end else begin
                     idx_in   = '0;
                     state_in = edfadm_pkg::ST_NEXT;
                  end
               end
               edfadm_pkg::FUNC_COMPLETE: begin
                  if (inf_hit_ff) begin
                     wr.kind_we = 1'b1;
                     wr.slot    = inf_slot_ff;
                     wr.kind    = edfadm_pkg::KIND_FREE;
                  end
               end
               default: ;
            endcase
         end

         // Outer step of the demand test: pick item k's deadline.
         edfadm_pkg::ST_OUTER: begin
            if (item_counted) begin
               dk_in    = item_dl;
               diff_in  = item_dl - req_ff.now_us;
               idx_in   = '0;
               sum_in   = '0;
               state_in = edfadm_pkg::ST_PROD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         // Supply bound for this deadline.
         edfadm_pkg::ST_PROD: begin
            prod_in  = edfadm_pkg::PROD_W'(cap_eff) * edfadm_pkg::PROD_W'(diff_ff);
            state_in = edfadm_pkg::ST_INNER;
         end

         // Inner step: add the cost of every counted item due no later.
         edfadm_pkg::ST_INNER: begin
            if (item_counted && item_dl <= dk_ff) begin
               sum_in = sum_ff + edfadm_pkg::SUM_W'(item_mag);
            end
            if (idx_ff == NEW_ITEM) begin
               state_in = edfadm_pkg::ST_CHECK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         edfadm_pkg::ST_CHECK: begin
            if (edfadm_pkg::PROD_W'(sum_ff) > prod_ff) begin
               res_in.status = edfadm_pkg::STAT_OVER;
               state_in      = edfadm_pkg::ST_RESP;
            end else if (k_ff == NEW_ITEM) begin
               state_in = edfadm_pkg::ST_PASS;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = edfadm_pkg::ST_OUTER;
            end
         end

         // Test passed: place the job in the table, or report full when no slot is free.
         edfadm_pkg::ST_PASS: begin
            state_in = edfadm_pkg::ST_RESP;
            if (req_ff.func == edfadm_pkg::FUNC_ADMIT && res_hit_ff) begin
               wr.we           = 1'b1;
               wr.slot         = res_slot_ff;
               wr.kind         = edfadm_pkg::KIND_RESERVED;
               res_in.accepted = 1'b1;
            end else if (free_hit_ff) begin
               wr.we           = 1'b1;
               wr.slot         = free_slot_ff;
               wr.kind         = (req_ff.func == edfadm_pkg::FUNC_ADMIT) ?
                                 edfadm_pkg::KIND_RESERVED : edfadm_pkg::KIND_PENDING;
               res_in.accepted = 1'b1;
            end else begin
               res_in.status = edfadm_pkg::STAT_FULL;
            end
         end

         // Pop: seek the popped id in flight, then free the entry or set it in flight.
         edfadm_pkg::ST_NEXT: begin
            if (rd_entry.kind == edfadm_pkg::KIND_INFLIGHT && rd_entry.id == pend_id_ff) begin
               dup_in = 1'b1;
            end
            if (idx_ff == LAST_SLOT) begin
               wr.kind_we        = 1'b1;
               wr.slot           = pend_slot_ff;
               wr.kind           = (dup_ff || (rd_entry.kind == edfadm_pkg::KIND_INFLIGHT &&
                                   rd_entry.id == pend_id_ff)) ?
                                   edfadm_pkg::KIND_FREE : edfadm_pkg::KIND_INFLIGHT;
               res_in.accepted   = 1'b1;
               res_in.job_id_out = pend_id_ff;
               state_in          = edfadm_pkg::ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         edfadm_pkg::ST_RESP: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = edfadm_pkg::ST_IDLE;
            end
         end

         default: state_in = edfadm_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != edfadm_pkg::ST_IDLE);
   assign res  = res_ff;

endmodule

### rtl/edf_admission_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF admission scheduler
// Earliest-deadline-first job table with demand-bound admission control.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; req_stall stays high until its
// response has been handed to the output register. Every request first walks
// the table one entry per cycle. Complete, a reserved-id enqueue and a failed
// or trivial admit or enqueue then decide and respond directly; next, when a
// pending entry exists, walks the table once more looking for a duplicate
// in-flight id. A full admission test runs one shared compare, add and
// multiply path: for each of the counted items (up to MAX_JOBS + 1) it forms
// the supply bound for that item's deadline and sums the costs of all items
// due no later, skipping uncounted entries. The response sits in a register
// so the next request can be taken while it waits. csr_wdata sets the
// processor count, with zero treated as one.
// ----------------------------------------------------------------------------
module edf_admission_scheduler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  edfadm_pkg::req_type            req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output edfadm_pkg::rsp_type            rsp_data,
   input  logic                           csr_we,
   input  logic [edfadm_pkg::CAP_W-1:0]   csr_wdata
);

   logic [edfadm_pkg::CAP_W-1:0]      cap_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   edfadm_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic                              busy;
   logic                              res_load;
   logic                              out_free;
   logic                              start;
   edfadm_pkg::rsp_type               res;
   logic [edfadm_pkg::SLOT_W-1:0]     rd_slot;
   edfadm_pkg::entry_type             rd_entry;
   edfadm_pkg::wr_type                wr;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= edfadm_pkg::CAP_W'(1);
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // Output register.
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign start     = req_valid && !busy;
   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   edfadm_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (rd_slot),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   edfadm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .cap      (cap_ff),
      .out_free (out_free),
      .busy     (busy),
      .res_load (res_load),
      .res      (res),
      .rd_slot  (rd_slot),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // An accepted beat keeps the block busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting a request");

   // Accepted responses always carry status ok.
   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |-> (rsp_data.status == edfadm_pkg::STAT_OK))
      else $error("accepted response with error status");

   // A handed-out id only comes with an accepted response.
   a_id_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.job_id_out != '0) |-> rsp_data.accepted)
      else $error("job id out without acceptance");

   // A response is loaded only when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid || !rsp_stall))
      else $error("response loaded over a held beat");

endmodule
